FILE: src/mpe_midi_stream_parser_macros.svh
// Assertion helpers used by mpe_midi_stream_parser.sv.
`ifndef MPE_MIDI_STREAM_PARSER_MACROS_SVH
`define MPE_MIDI_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mpe parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mpe parser assertion failed");

`endif

FILE: src/mpe_pkg.sv
package mpe_pkg;

	localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
	localparam logic [7:0] ST_NOTE_ON    = 8'h90;
	localparam logic [7:0] ST_CTRL       = 8'hB0;
	localparam logic [7:0] ST_PROGRAM    = 8'hC0;
	localparam logic [7:0] ST_PRESSURE   = 8'hD0;
	localparam logic [7:0] ST_BEND       = 8'hE0;
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_MTC        = 8'hF1;
	localparam logic [7:0] ST_SONG_POS   = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
	localparam logic [7:0] ST_SYSEX_END  = 8'hF7;
	localparam logic [7:0] ST_REALTIME   = 8'hF8;

	localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
	localparam logic [6:0] CC_SLIDE      = 7'd74;
	localparam logic [6:0] CC_RPN_FINE   = 7'd100;
	localparam logic [6:0] CC_RPN_COARSE = 7'd101;
	localparam logic [6:0] RPN_MPE_COARSE = 7'd0;
	localparam logic [6:0] RPN_MPE_FINE   = 7'd6;
	localparam logic [6:0] RPN_NULL       = 7'd127;

	localparam logic [1:0] KIND_NOTE     = 2'd0;
	localparam logic [1:0] KIND_BEND     = 2'd1;
	localparam logic [1:0] KIND_PRESSURE = 2'd2;
	localparam logic [1:0] KIND_SLIDE    = 2'd3;

	localparam logic [1:0] ROLE_OUTSIDE  = 2'd0;
	localparam logic [1:0] ROLE_MEMBER   = 2'd1;
	localparam logic [1:0] ROLE_MASTER   = 2'd2;

	localparam logic       REG_ZONE_SELECT  = 1'b0;
	localparam logic       REG_INITIAL_COUNT = 1'b1;
	localparam logic [3:0] INITIAL_COUNT_RESET = 4'd15;

	typedef struct packed {
		logic [7:0] running_status;
		logic       data_index;
		logic [1:0] system_bytes_left;
		logic       in_sysex_dump;
		logic [6:0] rpn_coarse;
		logic [6:0] rpn_fine;
		logic [3:0] member_count;
	} parser_state_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [1:0]  role;
		logic [4:0]  channel;
		logic [13:0] event_value;
		logic [6:0]  velocity;
	} mpe_event_t;

endpackage

FILE: src/mpe_stream_if.sv
interface mpe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] midi_byte;

	modport source(output valid, output midi_byte, input ready);
	modport sink(input valid, input midi_byte, output ready);
endinterface

interface mpe_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [1:0]  role;
	logic [4:0]  channel;
	logic [13:0] event_value;
	logic [6:0]  velocity;

	modport source(output valid, output event_kind, output role, output channel,
		output event_value, output velocity, input ready);
	modport sink(input valid, input event_kind, input role, input channel,
		input event_value, input velocity, output ready);
endinterface

FILE: src/mpe_midi_stream_parser.sv
// Channel   Dir   Payload                                           Width
// midi      in    midi_byte                                         8
// result    out   event_kind, role, channel, event_value, velocity  2/2/5/14/7
// cfg       in    cfg_we, cfg_index, cfg_data                       1/1/4
//
// A new byte may be accepted each cycle while midi.ready is high.
// A result appears on the output register the cycle after its last byte.
// The result register is the only stall point: midi is held off only while
// a result waits and result.ready is low. Reset initialises the parser state but not first_data_byte_q or out_q.
`include "mpe_midi_stream_parser_macros.svh"

module mpe_midi_stream_parser
	import mpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	mpe_byte_if.sink    midi,
	mpe_event_if.source result
);

	parser_state_t st_q;
	parser_state_t st_next;
	parser_state_t st_d;
	logic [6:0]    first_data_byte_q;
	logic          zone_select_q;
	logic          first_we;
	logic          emit;
	mpe_event_t    ev;
	mpe_event_t    out_q;
	logic          out_valid_q;
	logic          accept;

	assign midi.ready = !out_valid_q || result.ready;
	assign accept     = midi.valid && midi.ready;

	mpe_step u_step (
		.midi_byte       (midi.midi_byte),
		.st              (st_q),
		.first_data_byte (first_data_byte_q),
		.zone_select     (zone_select_q),
		.st_next         (st_next),
		.first_we        (first_we),
		.emit            (emit),
		.ev              (ev)
	);

	// A write of the initial member count loads the live count; no separate copy is kept.
	always_comb begin
		st_d = accept ? st_next : st_q;
		if (cfg_we && cfg_index == REG_INITIAL_COUNT) begin
			st_d.member_count = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_select_q     <= 1'b0;
			st_q.running_status    <= 8'd0;
			st_q.data_index        <= 1'b0;
			st_q.system_bytes_left <= 2'd0;
			st_q.in_sysex_dump     <= 1'b0;
			st_q.rpn_coarse        <= RPN_NULL;
			st_q.rpn_fine          <= RPN_NULL;
			st_q.member_count      <= INITIAL_COUNT_RESET;
			out_valid_q       <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we && cfg_index == REG_ZONE_SELECT) begin
				zone_select_q <= cfg_data[0];
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && first_we) begin
			first_data_byte_q <= midi.midi_byte[6:0];
		end
		if (accept && emit) begin
			out_q <= ev;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.event_kind  = out_q.event_kind;
	assign result.role        = out_q.role;
	assign result.channel     = out_q.channel;
	assign result.event_value = out_q.event_value;
	assign result.velocity    = out_q.velocity;

	// Real-time bytes leave the framing state untouched.
	`MPE_ASSERT_NEXT(a_realtime_stable, clk, arst_n,
		accept && !cfg_we && midi.midi_byte >= ST_REALTIME, $stable(st_q))
	// A channel status byte becomes running status and restarts data counting.
	`MPE_ASSERT_NEXT(a_status_loads, clk, arst_n,
		accept && !cfg_we && midi.midi_byte[7] && midi.midi_byte[7:4] != ST_SYSEX[7:4],
		st_q.running_status == $past(midi.midi_byte) && !st_q.data_index)
	// A waiting result is never dropped while the sink stalls.
	`MPE_ASSERT_NEXT(a_result_held, clk, arst_n,
		out_valid_q && !result.ready, out_valid_q && $stable(out_q))
	// Data bytes inside a sysex dump never produce a result.
	`MPE_ASSERT_IMPL(a_sysex_silent, clk, arst_n,
		accept && st_q.in_sysex_dump && !midi.midi_byte[7], !emit)

endmodule

FILE: src/mpe_step.sv
module mpe_step
	import mpe_pkg::*;
(
	input  logic [7:0]    midi_byte,
	input  parser_state_t st,
	input  logic [6:0]    first_data_byte,
	input  logic          zone_select,
	output parser_state_t st_next,
	output logic          first_we,
	output logic          emit,
	output mpe_event_t    ev
);

	logic [3:0] hi;
	logic [3:0] nib;
	logic [3:0] master_nib;
	logic       one_byte_msg;
	logic [6:0] a;
	logic [6:0] b;
	logic [6:0] v7;
	logic [4:0] nib_sum;
	logic       is_master;

	assign hi         = st.running_status[7:4];
	assign nib        = st.running_status[3:0];
	assign master_nib = zone_select ? 4'd15 : 4'd0;
	assign is_master  = (nib == master_nib);
	assign v7         = midi_byte[6:0];
	assign one_byte_msg = (hi == ST_PROGRAM[7:4]) || (hi == ST_PRESSURE[7:4]);
	assign a          = one_byte_msg ? v7 : first_data_byte;
	assign b          = one_byte_msg ? 7'd0 : v7;
	assign nib_sum    = {1'b0, nib} + {1'b0, st.member_count};

	always_comb begin
		st_next  = st;
		first_we = 1'b0;
		emit     = 1'b0;
		ev.event_kind  = KIND_NOTE;
		ev.event_value = {7'd0, a};
		ev.velocity    = 7'd0;
		ev.channel     = {1'b0, nib} + 5'd1;
		if (is_master) begin
			ev.role = ROLE_MASTER;
		end else if (!zone_select && nib >= 4'd1 && nib <= st.member_count) begin
			ev.role = ROLE_MEMBER;
		end else if (zone_select && nib <= 4'd14 && nib_sum >= 5'd15) begin
			ev.role = ROLE_MEMBER;
		end else begin
			ev.role = ROLE_OUTSIDE;
		end

		if (midi_byte >= ST_REALTIME) begin
			st_next = st;
		end else if (midi_byte[7]) begin
			if (st.in_sysex_dump) begin
				st_next.in_sysex_dump = 1'b0;
			end
			if (!(st.in_sysex_dump && midi_byte == ST_SYSEX_END)) begin
				st_next.data_index        = 1'b0;
				st_next.system_bytes_left = 2'd0;
				if (midi_byte[7:4] == ST_SYSEX[7:4]) begin
					st_next.running_status = 8'd0;
					if (midi_byte == ST_SYSEX) begin
						st_next.in_sysex_dump = 1'b1;
					end else if (midi_byte == ST_SONG_POS) begin
						st_next.system_bytes_left = 2'd2;
					end else if (midi_byte == ST_MTC || midi_byte == ST_SONG_SEL) begin
						st_next.system_bytes_left = 2'd1;
					end
				end else begin
					st_next.running_status = midi_byte;
				end
			end
		end else if (st.in_sysex_dump) begin
			st_next = st;
		end else if (st.system_bytes_left != 2'd0) begin
			st_next.system_bytes_left = st.system_bytes_left - 2'd1;
		end else if (st.running_status != 8'd0) begin
			if (!one_byte_msg && !st.data_index) begin
				first_we           = 1'b1;
				st_next.data_index = 1'b1;
			end else begin
				st_next.data_index = 1'b0;
				case (hi)
					ST_NOTE_ON[7:4]: begin
						emit        = 1'b1;
						ev.velocity = b;
					end
					ST_NOTE_OFF[7:4]: begin
						emit = 1'b1;
					end
					ST_PRESSURE[7:4]: begin
						emit          = 1'b1;
						ev.event_kind = KIND_PRESSURE;
					end
					ST_BEND[7:4]: begin
						emit           = 1'b1;
						ev.event_kind  = KIND_BEND;
						ev.event_value = {b, a};
					end
					ST_CTRL[7:4]: begin
						if (is_master && a == CC_RPN_COARSE) begin
							st_next.rpn_coarse = b;
						end else if (is_master && a == CC_RPN_FINE) begin
							st_next.rpn_fine = b;
						end else if (is_master && a == CC_DATA_ENTRY
								&& st.rpn_coarse == RPN_MPE_COARSE
								&& st.rpn_fine == RPN_MPE_FINE) begin
							st_next.member_count = (b > 7'd15) ? 4'd15 : b[3:0];
						end else if (a == CC_SLIDE) begin
							emit           = 1'b1;
							ev.event_kind  = KIND_SLIDE;
							ev.event_value = {7'd0, b};
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

endmodule
